/* rtl/prc_pkg.sv */
// Package: shared width, config register indices, state types and divider request/response structs.
package prc_pkg;

    localparam int CW = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EDGE,
        S_WAIT,
        S_BUILD,
        S_EMIT,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } t_md_state;

    localparam logic [2:0] REG_X_MIN = 3'd0;
    localparam logic [2:0] REG_X_MAX = 3'd1;
    localparam logic [2:0] REG_Y_MIN = 3'd2;
    localparam logic [2:0] REG_Y_MAX = 3'd3;

    typedef struct packed {
        logic          start;
        logic [CW-1:0] a;
        logic [CW-1:0] b;
        logic [CW-1:0] d;
    } t_md_req;

    typedef struct packed {
        logic          done;
        logic [CW-1:0] q;
    } t_md_rsp;

endpackage

/* rtl/prc_vtx_in_if.sv */
// Interface: polyline vertex input channel.
interface prc_vtx_in_if;
    logic                        valid;
    logic                        ready;
    logic signed [prc_pkg::CW-1:0] px;
    logic signed [prc_pkg::CW-1:0] py;
    logic                        poly_end;

    modport source (output valid, output px, output py, output poly_end, input ready);
    modport sink   (input valid, input px, input py, input poly_end, output ready);
endinterface

/* rtl/prc_vtx_out_if.sv */
// Interface: clipped strip vertex output channel.
interface prc_vtx_out_if;
    logic                        valid;
    logic                        ready;
    logic signed [prc_pkg::CW-1:0] vx;
    logic signed [prc_pkg::CW-1:0] vy;
    logic                        strip_begin;
    logic                        strip_finish;
    logic                        run_last;

    modport source (output valid, output vx, output vy, output strip_begin,
                    output strip_finish, output run_last, input ready);
    modport sink   (input valid, input vx, input vy, input strip_begin,
                    input strip_finish, input run_last, output ready);
endinterface

/* rtl/prc_muldiv.sv */
// Iterative unsigned a*b/d: shift-add multiply, then restoring divide.
module prc_muldiv (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  prc_pkg::t_md_req i_req,
    output prc_pkg::t_md_rsp o_rsp
);
    import prc_pkg::*;

    localparam int CNTW = $clog2(CW);

    t_md_state r_state, n_state;
    logic [CW-1:0]   r_hi, n_hi;
    logic [CW-1:0]   r_lo, n_lo;
    logic [CW-1:0]   r_a, n_a;
    logic [CW-1:0]   r_d, n_d;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic            r_done, n_done;

    logic [CW:0] sum;
    logic [CW:0] trial;
    logic [CW:0] diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MD_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_hi  <= n_hi;
        r_lo  <= n_lo;
        r_a   <= n_a;
        r_d   <= n_d;
        r_cnt <= n_cnt;
    end

    always_comb begin
        n_state = r_state;
        n_hi    = r_hi;
        n_lo    = r_lo;
        n_a     = r_a;
        n_d     = r_d;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        sum     = {1'b0, r_hi} + {1'b0, r_a};
        trial   = {r_hi, r_lo[CW-1]};
        diff    = trial - {1'b0, r_d};
        case (r_state)
            MD_IDLE: begin
                if (i_req.start) begin
                    n_hi    = '0;
                    n_lo    = i_req.b;
                    n_a     = i_req.a;
                    n_d     = i_req.d;
                    n_cnt   = '0;
                    n_state = MD_MUL;
                end
            end
            MD_MUL: begin
                if (r_lo[0]) begin
                    n_hi = sum[CW:1];
                    n_lo = {sum[0], r_lo[CW-1:1]};
                end else begin
                    n_hi = {1'b0, r_hi[CW-1:1]};
                    n_lo = {r_hi[0], r_lo[CW-1:1]};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNTW'(CW - 1)) begin
                    n_cnt   = '0;
                    n_state = MD_DIV;
                end
            end
            MD_DIV: begin
                if (trial >= {1'b0, r_d}) begin
                    n_hi = diff[CW-1:0];
                    n_lo = {r_lo[CW-2:0], 1'b1};
                end else begin
                    n_hi = trial[CW-1:0];
                    n_lo = {r_lo[CW-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNTW'(CW - 1)) begin
                    n_done  = 1'b1;
                    n_state = MD_IDLE;
                end
            end
            default: n_state = MD_IDLE;
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_lo;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> r_state == MD_IDLE)
        else $error("divider started while busy");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == MD_IDLE)
        else $error("done while busy");
    a_div_follows_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == MD_DIV && $past(r_state) != MD_DIV) |-> $past(r_state) == MD_MUL)
        else $error("divide phase without multiply");
`endif
endmodule

/* rtl/polyline_rect_clipper_core.sv */
// Top level: streaming polyline clipper against a configured rectangle.
//
//   channel   dir  port      payload
//   vertex    in   i_vtx     px, py, poly_end
//   strip     out  o_vtx     vx, vy, strip_begin, strip_finish, run_last
//   config    in   i_cfg_*   we, idx, data
//
// One vertex runs through these steps: accept, an edge test per edge, a run of the shared
// multiply/divide unit for each edge that crosses (up to four), build, the emission of each
// result (held while the output stalls), and a finish step; some vertices skip the edge tests.
// Reset: synchronous, active low; clears rectangle to its defaults and polyline state.
// Input ready only while idle; a stalled output holds the sequencer in its emit step.
module polyline_rect_clipper_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    prc_vtx_in_if.sink               i_vtx,
    prc_vtx_out_if.source            o_vtx,
    input  logic                     i_cfg_we,
    input  logic [2:0]               i_cfg_idx,
    input  logic [prc_pkg::CW-1:0]   i_cfg_data
);
    import prc_pkg::*;

    localparam int DW = CW + 1;
    localparam int OW = CW + 2;

    t_state r_state, n_state;

    logic signed [CW-1:0] r_xmin, r_xmax, r_ymin, r_ymax;
    logic signed [CW-1:0] r_px, r_py, n_px, n_py;
    logic signed [CW-1:0] r_cx, r_cy, n_cx, n_cy;
    logic r_end, n_end, r_ins, n_ins;
    logic r_pin, n_pin, r_have, n_have, r_open, n_open, r_fh, n_fh;
    logic [1:0] r_k, n_k;
    logic [1:0] r_cnt, n_cnt;
    logic signed [CW-1:0] r_hx [2];
    logic signed [CW-1:0] r_hy [2];
    logic signed [CW-1:0] n_hx [2];
    logic signed [CW-1:0] n_hy [2];
    logic signed [CW-1:0] r_rx [2];
    logic signed [CW-1:0] r_ry [2];
    logic signed [CW-1:0] n_rx [2];
    logic signed [CW-1:0] n_ry [2];
    logic [1:0] r_rfin, n_rfin;
    logic [1:0] r_n, n_n;
    logic r_ei, n_ei;

    t_md_req md_req;
    t_md_rsp md_rsp;

    logic in_ins, skip, accept;
    logic vert;
    logic signed [CW-1:0] a1, a2, b1, b2, e, lo_lim, hi_lim;
    logic signed [DW-1:0] da, de, de2, db;
    logic [DW-1:0] mda, mde, mdb;
    logic same, elig, neg;
    logic signed [OW-1:0] oval;
    logic in_rng;

    prc_muldiv u_md (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (md_req),
        .o_rsp  (md_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_xmin  <= '0;
            r_xmax  <= {1'b0, {(CW-1){1'b1}}};
            r_ymin  <= '0;
            r_ymax  <= {1'b0, {(CW-1){1'b1}}};
            r_px    <= '0;
            r_py    <= '0;
            r_pin   <= 1'b0;
            r_have  <= 1'b0;
            r_open  <= 1'b0;
            r_fh    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_px    <= n_px;
            r_py    <= n_py;
            r_pin   <= n_pin;
            r_have  <= n_have;
            r_open  <= n_open;
            r_fh    <= n_fh;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_X_MIN: r_xmin <= i_cfg_data;
                    REG_X_MAX: r_xmax <= i_cfg_data;
                    REG_Y_MIN: r_ymin <= i_cfg_data;
                    REG_Y_MAX: r_ymax <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_cx   <= n_cx;
        r_cy   <= n_cy;
        r_end  <= n_end;
        r_ins  <= n_ins;
        r_k    <= n_k;
        r_cnt  <= n_cnt;
        r_hx   <= n_hx;
        r_hy   <= n_hy;
        r_rx   <= n_rx;
        r_ry   <= n_ry;
        r_rfin <= n_rfin;
        r_n    <= n_n;
        r_ei   <= n_ei;
    end

    // edge geometry for the current edge under test
    always_comb begin
        vert = !r_k[1];
        case (r_k)
            2'd0:    e = r_xmin;
            2'd1:    e = r_xmax;
            2'd2:    e = r_ymin;
            default: e = r_ymax;
        endcase
        a1     = vert ? r_px : r_py;
        a2     = vert ? r_cx : r_cy;
        b1     = vert ? r_py : r_px;
        b2     = vert ? r_cy : r_cx;
        lo_lim = vert ? r_ymin : r_xmin;
        hi_lim = vert ? r_ymax : r_xmax;
        da     = DW'(a2) - DW'(a1);
        de     = DW'(e) - DW'(a1);
        de2    = DW'(e) - DW'(a2);
        db     = DW'(b2) - DW'(b1);
        mda    = da[DW-1] ? -da : da;
        mde    = de[DW-1] ? -de : de;
        mdb    = db[DW-1] ? -db : db;
        same   = (de > 0 && de2 > 0) || (de < 0 && de2 < 0);
        elig   = (da != '0) && !same;
        neg    = db[DW-1] ^ de[DW-1] ^ da[DW-1];
        oval   = neg ? OW'(b1) - OW'({1'b0, md_rsp.q})
                     : OW'(b1) + OW'({1'b0, md_rsp.q});
        in_rng = !(oval < OW'(lo_lim) || oval > OW'(hi_lim));
    end

    assign in_ins = !(i_vtx.px < r_xmin || i_vtx.px > r_xmax ||
                      i_vtx.py < r_ymin || i_vtx.py > r_ymax);
    assign skip   = (r_px < r_xmin && i_vtx.px < r_xmin) ||
                    (r_px > r_xmax && i_vtx.px > r_xmax) ||
                    (r_py < r_ymin && i_vtx.py < r_ymin) ||
                    (r_py > r_ymax && i_vtx.py > r_ymax);
    assign accept = i_vtx.valid && i_vtx.ready;

    always_comb begin
        n_state = r_state;
        n_px = r_px;  n_py = r_py;  n_cx = r_cx;  n_cy = r_cy;
        n_end = r_end;  n_ins = r_ins;  n_pin = r_pin;  n_have = r_have;
        n_open = r_open;  n_fh = r_fh;  n_k = r_k;  n_cnt = r_cnt;
        n_hx = r_hx;  n_hy = r_hy;  n_rx = r_rx;  n_ry = r_ry;
        n_rfin = r_rfin;  n_n = r_n;  n_ei = r_ei;
        md_req.start = 1'b0;
        md_req.a     = mdb[CW-1:0];
        md_req.b     = mde[CW-1:0];
        md_req.d     = mda[CW-1:0];
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cx  = i_vtx.px;
                    n_cy  = i_vtx.py;
                    n_end = i_vtx.poly_end;
                    n_ins = in_ins;
                    n_k   = 2'd0;
                    n_cnt = 2'd0;
                    if (!r_have)
                        n_state = S_FIN;
                    else if (r_pin && in_ins)
                        n_state = S_BUILD;
                    else if (!r_pin && !in_ins && skip)
                        n_state = S_FIN;
                    else
                        n_state = S_EDGE;
                end
            end
            S_EDGE: begin
                if (elig) begin
                    md_req.start = 1'b1;
                    n_state      = S_WAIT;
                end else if (r_k == 2'd3) begin
                    n_state = S_BUILD;
                end else begin
                    n_k = r_k + 2'd1;
                end
            end
            S_WAIT: begin
                if (md_rsp.done) begin
                    if (in_rng) begin
                        n_hx[r_cnt[0]] = vert ? e : oval[CW-1:0];
                        n_hy[r_cnt[0]] = vert ? oval[CW-1:0] : e;
                        n_cnt          = r_cnt + 2'd1;
                    end
                    if (r_k == 2'd3 || (in_rng && r_cnt == 2'd1)) begin
                        n_state = S_BUILD;
                    end else begin
                        n_k     = r_k + 2'd1;
                        n_state = S_EDGE;
                    end
                end
            end
            S_BUILD: begin
                n_ei = 1'b0;
                if (r_pin && r_ins) begin
                    n_rx[0]   = r_fh ? r_px : r_cx;
                    n_ry[0]   = r_fh ? r_py : r_cy;
                    n_rfin[0] = r_fh ? 1'b0 : r_end;
                    n_rx[1]   = r_cx;
                    n_ry[1]   = r_cy;
                    n_rfin[1] = r_end;
                    n_n       = r_fh ? 2'd2 : 2'd1;
                end else if (!r_pin && !r_ins) begin
                    n_rx[0]   = r_hx[0];
                    n_ry[0]   = r_hy[0];
                    n_rfin[0] = 1'b0;
                    n_rx[1]   = r_hx[1];
                    n_ry[1]   = r_hy[1];
                    n_rfin[1] = 1'b1;
                    n_n       = (r_cnt == 2'd2) ? 2'd2 : 2'd0;
                end else if (r_ins) begin
                    n_rx[0]   = (r_cnt != 2'd0) ? r_hx[0] : r_cx;
                    n_ry[0]   = (r_cnt != 2'd0) ? r_hy[0] : r_cy;
                    n_rfin[0] = 1'b0;
                    n_rx[1]   = r_cx;
                    n_ry[1]   = r_cy;
                    n_rfin[1] = r_end;
                    n_n       = 2'd2;
                end else begin
                    n_rx[0]   = r_fh ? r_px : ((r_cnt != 2'd0) ? r_hx[0] : r_px);
                    n_ry[0]   = r_fh ? r_py : ((r_cnt != 2'd0) ? r_hy[0] : r_py);
                    n_rfin[0] = !r_fh;
                    n_rx[1]   = (r_cnt != 2'd0) ? r_hx[0] : r_px;
                    n_ry[1]   = (r_cnt != 2'd0) ? r_hy[0] : r_py;
                    n_rfin[1] = 1'b1;
                    n_n       = r_fh ? 2'd2 : 2'd1;
                end
                n_state = (n_n == 2'd0) ? S_FIN : S_EMIT;
            end
            S_EMIT: begin
                if (o_vtx.ready) begin
                    n_open = !r_rfin[r_ei];
                    if ({1'b0, r_ei} == r_n - 2'd1)
                        n_state = S_FIN;
                    else
                        n_ei = 1'b1;
                end
            end
            S_FIN: begin
                n_px    = r_cx;
                n_py    = r_cy;
                n_pin   = r_ins;
                n_fh    = r_have ? 1'b0 : r_ins;
                n_have  = 1'b1;
                if (r_end) begin
                    n_have = 1'b0;
                    n_fh   = 1'b0;
                    n_open = 1'b0;
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign i_vtx.ready        = (r_state == S_IDLE);
    assign o_vtx.valid        = (r_state == S_EMIT);
    assign o_vtx.vx           = r_rx[r_ei];
    assign o_vtx.vy           = r_ry[r_ei];
    assign o_vtx.strip_begin  = !r_open;
    assign o_vtx.strip_finish = r_rfin[r_ei];
    assign o_vtx.run_last     = ({1'b0, r_ei} == r_n - 2'd1);

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_vtx.ready |-> !o_vtx.valid)
        else $error("input ready while results pending");
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_vtx.valid && o_vtx.ready && o_vtx.run_last) |=> !o_vtx.valid)
        else $error("result after last transaction of a vertex");
    a_end_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_vtx.valid && o_vtx.run_last && r_end) |-> o_vtx.strip_finish)
        else $error("final vertex does not finish strip");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WAIT |-> r_cnt != 2'd2 && r_cnt != 2'd3)
        else $error("crossing count overrun");
`endif
endmodule

/* tb/prc_tb_pkg.sv */
// Scoreboard class: clips polyline vertices to the rectangle and checks the emitted strips.
package prc_tb_pkg;

    typedef struct {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic               strip_begin;
        logic               strip_finish;
        logic               run_last;
    } t_strip_vtx;

    class clip_scoreboard;
        longint x_min, x_max, y_min, y_max;
        longint last_x, last_y;
        bit     last_in, seen_vtx, strip_open, first_pending;
        t_strip_vtx pending_q[$];
        t_strip_vtx step_q[$];
        int     mismatches;
        int     results_seen;
        int     polylines_seen;

        function new();
            x_min = 0;
            x_max = 64'sd2147483647;
            y_min = 0;
            y_max = 64'sd2147483647;
            last_x = 0;
            last_y = 0;
            last_in = 0;
            seen_vtx = 0;
            strip_open = 0;
            first_pending = 0;
            mismatches = 0;
            results_seen = 0;
            polylines_seen = 0;
        endfunction

        function void set_edge(int idx, logic [31:0] data);
            longint v;
            v = longint'(signed'(data));
            case (idx)
                0: x_min = v;
                1: x_max = v;
                2: y_min = v;
                3: y_max = v;
                default: ;
            endcase
        endfunction

        function longint lerp(longint a1, longint b1, longint a2, longint b2, longint e);
            logic signed [127:0] num;
            logic signed [127:0] q;
            longint db, de, da;
            db = b2 - b1;
            de = e - a1;
            da = a2 - a1;
            if (db == 0 || de == 0)
                return b1;
            num = 128'(db) * 128'(de);
            q = num / 128'(da);
            return b1 + longint'(q);
        endfunction

        function bit is_inside(longint x, longint y);
            return !(x < x_min || x > x_max || y < y_min || y > y_max);
        endfunction

        function bit same_sign(longint d1, longint d2);
            return (d1 > 0 && d2 > 0) || (d1 < 0 && d2 < 0);
        endfunction

        function int edge_hits(longint x1, longint y1, longint x2, longint y2,
                               output longint hx[2], output longint hy[2]);
            int     cnt;
            longint e, ox, oy;
            cnt = 0;
            hx[0] = 0; hx[1] = 0; hy[0] = 0; hy[1] = 0;
            for (int k = 0; k < 4; k++) begin
                e = (k == 0) ? x_min : (k == 1) ? x_max : (k == 2) ? y_min : y_max;
                if (k < 2) begin
                    if (x1 == x2 || same_sign(e - x1, e - x2))
                        continue;
                    ox = e;
                    oy = lerp(x1, y1, x2, y2, e);
                    if (oy < y_min || oy > y_max)
                        continue;
                end else begin
                    if (y1 == y2 || same_sign(e - y1, e - y2))
                        continue;
                    oy = e;
                    ox = lerp(y1, x1, y2, x2, e);
                    if (ox < x_min || ox > x_max)
                        continue;
                end
                if (cnt < 2) begin
                    hx[cnt] = ox;
                    hy[cnt] = oy;
                end
                cnt++;
            end
            return cnt;
        endfunction

        function void push_vtx(longint x, longint y, bit fin);
            t_strip_vtx r;
            r.vx = x[31:0];
            r.vy = y[31:0];
            r.strip_begin = !strip_open;
            r.strip_finish = fin;
            r.run_last = 0;
            strip_open = !fin;
            step_q.push_back(r);
        endfunction

        function void note_vertex(logic [31:0] px, logic [31:0] py, bit pend);
            longint x, y, hx[2], hy[2];
            bit     ins, skip;
            int     cnt;
            x = longint'(signed'(px));
            y = longint'(signed'(py));
            ins = is_inside(x, y);
            step_q.delete();
            if (!seen_vtx) begin
                first_pending = ins;
            end else if (last_in && ins) begin
                if (first_pending)
                    push_vtx(last_x, last_y, 0);
                push_vtx(x, y, pend);
            end else if (!last_in && !ins) begin
                skip = (last_x < x_min && x < x_min) || (last_x > x_max && x > x_max) ||
                       (last_y < y_min && y < y_min) || (last_y > y_max && y > y_max);
                if (!skip && edge_hits(last_x, last_y, x, y, hx, hy) >= 2) begin
                    push_vtx(hx[0], hy[0], 0);
                    push_vtx(hx[1], hy[1], 1);
                end
            end else begin
                cnt = edge_hits(last_x, last_y, x, y, hx, hy);
                if (ins) begin
                    if (cnt > 0) push_vtx(hx[0], hy[0], 0);
                    else push_vtx(x, y, 0);
                    push_vtx(x, y, pend);
                end else begin
                    if (first_pending)
                        push_vtx(last_x, last_y, 0);
                    if (cnt > 0) push_vtx(hx[0], hy[0], 1);
                    else push_vtx(last_x, last_y, 1);
                end
            end
            if (seen_vtx)
                first_pending = 0;
            last_x = x;
            last_y = y;
            last_in = ins;
            seen_vtx = 1;
            if (pend) begin
                seen_vtx = 0;
                first_pending = 0;
                strip_open = 0;
                polylines_seen++;
            end
            if (step_q.size() > 0)
                step_q[step_q.size() - 1].run_last = 1;
            foreach (step_q[i])
                pending_q.push_back(step_q[i]);
        endfunction

        function void check_strip_vtx(t_strip_vtx got);
            t_strip_vtx exp_v;
            results_seen++;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected strip vertex (%0d,%0d) b=%0b f=%0b l=%0b",
                             got.vx, got.vy, got.strip_begin, got.strip_finish,
                             got.run_last);
                return;
            end
            exp_v = pending_q.pop_front();
            if (got.vx !== exp_v.vx || got.vy !== exp_v.vy ||
                got.strip_begin !== exp_v.strip_begin ||
                got.strip_finish !== exp_v.strip_finish ||
                got.run_last !== exp_v.run_last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: exp (%0d,%0d) b=%0b f=%0b l=%0b got (%0d,%0d) b=%0b f=%0b l=%0b",
                             exp_v.vx, exp_v.vy, exp_v.strip_begin, exp_v.strip_finish,
                             exp_v.run_last, got.vx, got.vy, got.strip_begin,
                             got.strip_finish, got.run_last);
            end
        endfunction
    endclass

endpackage

/* tb/testbench.sv */
// Testbench top: drives polylines and rectangle settings into the clipper and checks its strips.
module testbench;
    import prc_pkg::*;
    import prc_tb_pkg::*;

    localparam longint CYCLE_LIMIT = 2_000_000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [2:0]        i_cfg_idx;
    logic [CW-1:0]     i_cfg_data;
    logic              calm;
    longint            cycle_cnt = 0;
    int                vtx_sent;

    prc_vtx_in_if  vin();
    prc_vtx_out_if vout();

    clip_scoreboard sb;

    polyline_rect_clipper_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vtx      (vin),
        .o_vtx      (vout),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 0;
    end
    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && vout.valid && vout.ready) begin
            t_strip_vtx r;
            r.vx = vout.vx;
            r.vy = vout.vy;
            r.strip_begin = vout.strip_begin;
            r.strip_finish = vout.strip_finish;
            r.run_last = vout.run_last;
            sb.check_strip_vtx(r);
        end
    end

    // Sink side: random stall bursts, none once calm.
    initial begin
        int n;
        vout.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 3) == 0) begin
                vout.ready = 1'b0;
                n = $urandom_range(1, 10);
                repeat (n - 1) @(negedge i_clk);
                @(negedge i_clk);
            end
            vout.ready = 1'b1;
            n = $urandom_range(1, 10);
            repeat (n - 1) @(negedge i_clk);
        end
    end

    task automatic write_edge(input logic [2:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.set_edge(idx, data);
    endtask

    task automatic send_vtx(input logic [31:0] x, input logic [31:0] y, input bit pend);
        if (!calm && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        vin.valid = 1'b1;
        vin.px = x;
        vin.py = y;
        vin.poly_end = pend;
        @(posedge i_clk);
        while (!vin.ready) @(posedge i_clk);
        sb.note_vertex(x, y, pend);
        vtx_sent++;
        @(negedge i_clk);
        vin.valid = 1'b0;
    endtask

    task automatic drain();
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic set_rect(input logic [31:0] x0, input logic [31:0] x1,
                            input logic [31:0] y0, input logic [31:0] y1);
        drain();
        write_edge(REG_X_MIN, x0);
        write_edge(REG_X_MAX, x1);
        write_edge(REG_Y_MIN, y0);
        write_edge(REG_Y_MAX, y1);
    endtask

    function automatic logic [31:0] rand_coord(input int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 400)) - 200);
            default: return 32'($signed($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    task automatic rand_polyline(input int mode);
        int len;
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
            send_vtx(rand_coord(mode), rand_coord(mode), i == len - 1);
    endtask

    initial begin
        sb = new();
        calm = 1'b0;
        vtx_sent = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        vin.valid = 1'b0;
        vin.px = '0;
        vin.py = '0;
        vin.poly_end = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset rectangle: extremes, single point, wrap
        send_vtx(32'h8000_0000, 32'h8000_0000, 1);
        send_vtx(32'h7fff_ffff, 32'h7fff_ffff, 0);
        send_vtx(32'h0, 32'h0, 0);
        send_vtx(32'h8000_0000, 32'h7fff_ffff, 0);
        send_vtx(32'h7fff_ffff, 32'h8000_0000, 1);

        set_rect(-100, 100, -50, 50);
        // inside run, exit, re-entry, pass-through, corner pass, same-edge skip
        send_vtx(0, 0, 0);
        send_vtx(10, 10, 0);
        send_vtx(300, 10, 0);
        send_vtx(-300, 20, 0);
        send_vtx(-300, 200, 0);
        send_vtx(-200, 0, 0);
        send_vtx(0, 100, 0);
        send_vtx(-20, 0, 1);
        send_vtx(-200, -150, 0);
        send_vtx(200, 150, 1);
        send_vtx(0, 0, 0);
        send_vtx(500, 0, 1);
        send_vtx(100, 50, 0);
        send_vtx(100, 50, 1);

        set_rect(10, -10, 0, 100);   // empty rectangle
        for (int i = 0; i < 30; i++) rand_polyline(1);

        set_rect(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        for (int i = 0; i < 30; i++) rand_polyline(0);

        for (int ph = 0; ph < 8; ph++) begin
            int c;
            c = $urandom_range(1, 800);
            set_rect(-c, c, -$urandom_range(1, 800), $urandom_range(1, 800));
            if (ph == 6) calm = 1'b1;
            for (int i = 0; i < 30; i++) rand_polyline(ph == 3 ? 0 : 2);
        end

        set_rect($urandom, $urandom, $urandom, $urandom);
        for (int i = 0; i < 10; i++) rand_polyline(0);

        drain();
        $display("Ran %0d vertices in %0d polylines, checked %0d strip vertices",
                 vtx_sent, sb.polylines_seen, sb.results_seen);
        $display("Rectangles covered: reset, empty, full range, random boxes");
        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
